// ===== hdl/spq_pkg.sv =====
// Shared types for the sorted priority queue: transfer payloads, stored entry, cell command.
// No dependencies; used by spq_cell, sorted_priority_queue_core, spq_checker and tb.
package spq_pkg;

    localparam int ID_W   = 16;
    localparam int PRIO_W = 8;
    localparam int TAG_W  = 8;
    localparam int OCC_W  = 5;

    typedef enum logic {
        KIND_PUSH = 1'b0,
        KIND_POP  = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [ID_W-1:0]    item_id;
        logic [PRIO_W-1:0]  item_priority;
        logic [TAG_W-1:0]   item_tag;
    } t_in_item;

    typedef struct packed {
        logic               got_entry;
        logic [ID_W-1:0]    out_id;
        logic [PRIO_W-1:0]  out_priority;
        logic [TAG_W-1:0]   out_tag;
        logic               overflow;
        logic [OCC_W-1:0]   occupancy;
    } t_out_item;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [PRIO_W-1:0]  prio;
        logic [TAG_W-1:0]   tag;
    } t_entry;

    // Broadcast to every cell of the chain in the cycle of a transfer
    typedef struct packed {
        logic   push;
        logic   pop;
        t_entry entry;
    } t_cell_cmd;

endpackage

// ===== hdl/sorted_priority_queue_core.sv =====
// Sorted priority queue built from a chain of spq_cell slots with a fill counter and
// a registered result stage. Depends on spq_pkg and spq_cell.
//
// Each accepted item (push or pop) produces one result in the next cycle, and a new item
// is accepted every cycle as long as the result register is empty or being drained in the
// same cycle. This rate rests on the chain: every slot compares its priority with the
// pushed one and all slots shift by one place on the same edge, so the time of insert
// and pop does not grow with the fill level. The queue holds up to CAPACITY entries in
// ascending priority order; a push into a full queue is dropped with overflow set, and a
// pop of an empty queue returns got_entry low with zero fields. Stored entries need no
// clearing after reset: a slot counts only while it lies below the fill count.
module sorted_priority_queue_core #(
    parameter int CAPACITY = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  spq_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output spq_pkg::t_out_item o_out_item
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic [CW-1:0]      r_count;
    logic [CW-1:0]      n_count;
    logic               r_out_valid;
    spq_pkg::t_out_item r_out_item;
    spq_pkg::t_out_item n_out_item;

    spq_pkg::t_cell_cmd w_cmd;
    logic               w_accept;
    logic               w_full;
    logic               w_empty;
    logic [CW+spq_pkg::OCC_W-1:0] w_count_ext;

    logic            w_ge    [CAPACITY];
    spq_pkg::t_entry w_entry [CAPACITY];

    // Accept while the result slot is free or drains this cycle
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_full     = r_count == CW'(CAPACITY);
    assign w_empty    = r_count == '0;

    // Form the chain command
    always_comb begin
        w_cmd.push       = w_accept && (i_in_item.kind == spq_pkg::KIND_PUSH) && !w_full;
        w_cmd.pop        = w_accept && (i_in_item.kind == spq_pkg::KIND_POP) && !w_empty;
        w_cmd.entry.id   = i_in_item.item_id;
        w_cmd.entry.prio = i_in_item.item_priority;
        w_cmd.entry.tag  = i_in_item.item_tag;
    end

    // Build the chain
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic            w_left_ge;
        spq_pkg::t_entry w_left_entry;
        spq_pkg::t_entry w_right_entry;

        if (g == 0) begin : g_first
            assign w_left_ge    = 1'b0;
            assign w_left_entry = '0;
        end else begin : g_mid
            assign w_left_ge    = w_ge[g-1];
            assign w_left_entry = w_entry[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_right_entry = '0;
        end else begin : g_inner
            assign w_right_entry = w_entry[g+1];
        end

        spq_cell u_cell (
            .i_clk         (i_clk),
            .i_cmd         (w_cmd),
            .i_valid       (CW'(g) < r_count),
            .i_strict      (g == 0),
            .i_left_ge     (w_left_ge),
            .i_left_entry  (w_left_entry),
            .i_right_entry (w_right_entry),
            .o_ge          (w_ge[g]),
            .o_entry       (w_entry[g])
        );
    end

    // Next fill count and result
    always_comb begin
        n_count = r_count;
        if (w_cmd.push) begin
            n_count = r_count + CW'(1);
        end else if (w_cmd.pop) begin
            n_count = r_count - CW'(1);
        end

        w_count_ext = (CW + spq_pkg::OCC_W)'(n_count);

        n_out_item              = '0;
        n_out_item.occupancy    = w_count_ext[spq_pkg::OCC_W-1:0];
        n_out_item.overflow     = (i_in_item.kind == spq_pkg::KIND_PUSH) && w_full;
        if (w_cmd.pop) begin
            n_out_item.got_entry    = 1'b1;
            n_out_item.out_id       = w_entry[0].id;
            n_out_item.out_priority = w_entry[0].prio;
            n_out_item.out_tag      = w_entry[0].tag;
        end
    end

    // Hold count and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_accept) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// ===== hdl/spq_cell.sv =====
// One slot of the sorted chain: holds an entry and compares it with the pushed priority.
// Depends on spq_pkg.
module spq_cell (
    input  logic               i_clk,
    input  spq_pkg::t_cell_cmd i_cmd,
    input  logic               i_valid,       // slot lies below the fill count
    input  logic               i_strict,      // head slot: new entry goes only on strictly greater
    input  logic               i_left_ge,     // left neighbor takes the new entry or shifts
    input  spq_pkg::t_entry    i_left_entry,
    input  spq_pkg::t_entry    i_right_entry,
    output logic               o_ge,
    output spq_pkg::t_entry    o_entry
);

    spq_pkg::t_entry r_entry;
    logic            w_cmp;

    // Decide whether the new entry lands here or before this slot
    always_comb begin
        if (i_strict) begin
            w_cmp = r_entry.prio > i_cmd.entry.prio;
        end else begin
            w_cmp = r_entry.prio >= i_cmd.entry.prio;
        end
        o_ge = !i_valid || w_cmp;
    end

    // Shift right on insert, shift left on pop, otherwise hold
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            if (i_left_ge) begin
                r_entry <= i_left_entry;
            end else if (o_ge) begin
                r_entry <= i_cmd.entry;
            end
        end else if (i_cmd.pop) begin
            r_entry <= i_right_entry;
        end
    end

    assign o_entry = r_entry;

endmodule

// ===== hdl/spq_checker.sv =====
// Port-level checks for sorted_priority_queue_core, attached by the bind below.
// Depends on spq_pkg and sorted_priority_queue_core.
module spq_checker #(
    parameter int CAPACITY = 16
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input spq_pkg::t_in_item  i_in_item,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input spq_pkg::t_out_item o_out_item
);

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result changed while stalled");

    // No result is pending after reset
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // A transfer in always yields a result next cycle
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> o_out_valid)
        else $error("accepted item gave no result");

    // Pop and overflow exclude each other; a miss carries zero fields
    a_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_item.got_entry && o_out_item.overflow) &&
            (o_out_item.got_entry || (o_out_item.out_id == '0 &&
             o_out_item.out_priority == '0 && o_out_item.out_tag == '0)))
        else $error("inconsistent result fields");

    // For CAPACITY below 32, occupancy stays within capacity, and an overflow reports a full queue
    a_occupancy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (CAPACITY >= 32) ||
            ((32'(o_out_item.occupancy) <= CAPACITY) &&
             (!o_out_item.overflow || 32'(o_out_item.occupancy) == CAPACITY)))
        else $error("occupancy out of range");

endmodule

bind sorted_priority_queue_core spq_checker #(.CAPACITY(CAPACITY)) u_spq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);

// ===== tb/tb.sv =====
// Self-checking bench for sorted_priority_queue_core: directed and random push/pop traffic
// with bursts of idling on both channels, checked against a sorted queue kept in the bench.
// Depends on spq_pkg and the core RTL.
module tb;
    import spq_pkg::*;

    localparam int QUEUE_DEPTH  = 16;
    localparam int RANDOM_ITEMS = 1700;
    // Requests left in the queue below which neither side idles any more
    localparam int CALM_TAIL    = 200;
    localparam int SETTLE_TICKS = 8;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [PRIO_W-1:0] prio;
        logic [TAG_W-1:0]  tag;
    } slot_t;

    logic      clk;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_item  in_item   = '0;
    logic      out_ready = 1'b0;
    logic      in_ready;
    logic      out_valid;
    t_out_item out_item;

    t_in_item  request_q[$];
    t_out_item expected_resp_q[$];
    slot_t     model_slots[$];
    t_out_item want;
    int        send_gap       = 0;
    int        recv_stall     = 0;
    int        accepted_count = 0;
    int        error_count    = 0;

    sorted_priority_queue_core #(
        .CAPACITY(QUEUE_DEPTH)
    ) u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_item (out_item)
    );

    // Apply one accepted request to the bench copy of the queue and return its result
    function automatic t_out_item apply_to_sorted_model(t_in_item req);
        t_out_item res;
        slot_t     fresh;
        int        pos;
        res = '0;
        if (req.kind == KIND_PUSH) begin
            if (model_slots.size() >= QUEUE_DEPTH) begin
                res.overflow = 1'b1;
            end else begin
                fresh = {req.item_id, req.item_priority, req.item_tag};
                // A head of equal priority stays ahead; later equals are passed
                if (model_slots.size() == 0 || model_slots[0].prio > req.item_priority) begin
                    pos = 0;
                end else begin
                    pos = 1;
                    while (pos < model_slots.size() && model_slots[pos].prio < req.item_priority)
                        pos++;
                end
                model_slots.insert(pos, fresh);
            end
        end else if (model_slots.size() != 0) begin
            fresh            = model_slots.pop_front();
            res.got_entry    = 1'b1;
            res.out_id       = fresh.id;
            res.out_priority = fresh.prio;
            res.out_tag      = fresh.tag;
        end
        res.occupancy = OCC_W'(model_slots.size());
        return res;
    endfunction

    function automatic t_in_item make_req(t_kind kind, logic [ID_W-1:0] id,
                                          logic [PRIO_W-1:0] prio, logic [TAG_W-1:0] tag);
        t_in_item req;
        req.kind          = kind;
        req.item_id       = id;
        req.item_priority = prio;
        req.item_tag      = tag;
        return req;
    endfunction

    // Idle only away from the tail, and not in every stretch of traffic
    function automatic bit idling_allowed();
        return request_q.size() > CALM_TAIL && ((accepted_count / 96) % 4 != 3);
    endfunction

    task automatic check_field(string name, logic [ID_W-1:0] exp_v, logic [ID_W-1:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
            error_count++;
        end
    endtask

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Fill the request queue: directed cases first, then random segments
    initial begin
        int remaining;
        int seg_len;
        int push_pct;
        bit narrow;
        t_kind kind;
        logic [PRIO_W-1:0] prio;

        // Pop of an empty queue, then field extremes and priority ties
        request_q.push_back(make_req(KIND_POP,  16'h0000, 8'h00, 8'h00));
        request_q.push_back(make_req(KIND_PUSH, 16'hffff, 8'hff, 8'hff));
        request_q.push_back(make_req(KIND_PUSH, 16'h0000, 8'h00, 8'h00));
        request_q.push_back(make_req(KIND_PUSH, 16'h1111, 8'h00, 8'h11));
        request_q.push_back(make_req(KIND_PUSH, 16'h2222, 8'h00, 8'h22));
        request_q.push_back(make_req(KIND_PUSH, 16'h3333, 8'h80, 8'h33));
        request_q.push_back(make_req(KIND_PUSH, 16'h4444, 8'h80, 8'h44));
        request_q.push_back(make_req(KIND_PUSH, 16'h5555, 8'h7f, 8'h55));
        // Drain all seven entries, then pop empty with junk in the ignored fields
        repeat (7) request_q.push_back(make_req(KIND_POP, 16'h0000, 8'h00, 8'h00));
        request_q.push_back(make_req(KIND_POP, 16'hffff, 8'hff, 8'hff));

        // Segments lean toward filling, mixing or draining so full and empty both recur
        remaining = RANDOM_ITEMS;
        while (remaining > 0) begin
            seg_len = $urandom_range(10, 50);
            case ($urandom_range(0, 2))
                0: begin
                    push_pct = 85;
                end
                1: begin
                    push_pct = 50;
                end
                default: begin
                    push_pct = 15;
                end
            endcase
            narrow = $urandom_range(0, 1);
            repeat (seg_len) begin
                kind = ($urandom_range(0, 99) < push_pct) ? KIND_PUSH : KIND_POP;
                prio = narrow ? PRIO_W'($urandom_range(0, 3)) : PRIO_W'($urandom);
                request_q.push_back(make_req(kind, ID_W'($urandom), prio, TAG_W'($urandom)));
            end
            remaining -= seg_len;
        end
    end

    // Driver: record each transfer, then present the next request or idle
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end else if (!in_valid || in_ready) begin
            if (in_valid) begin
                expected_resp_q.push_back(apply_to_sorted_model(in_item));
                accepted_count <= accepted_count + 1;
            end
            if (send_gap != 0) begin
                send_gap <= send_gap - 1;
                in_valid <= 1'b0;
            end else if (request_q.size() != 0) begin
                in_item  <= request_q.pop_front();
                in_valid <= 1'b1;
                if (idling_allowed() && $urandom_range(0, 5) == 0)
                    send_gap <= $urandom_range(1, 5);
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Monitor: compare each result transfer with the oldest prediction, stall at random
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready  <= 1'b0;
            recv_stall <= 0;
        end else begin
            if (out_valid && out_ready) begin
                if (expected_resp_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none actual %0h", $time, out_item);
                    error_count++;
                end else begin
                    want = expected_resp_q.pop_front();
                    check_field("got_entry",    want.got_entry,    out_item.got_entry);
                    check_field("out_id",       want.out_id,       out_item.out_id);
                    check_field("out_priority", want.out_priority, out_item.out_priority);
                    check_field("out_tag",      want.out_tag,      out_item.out_tag);
                    check_field("overflow",     want.overflow,     out_item.overflow);
                    check_field("occupancy",    want.occupancy,    out_item.occupancy);
                end
            end
            if (recv_stall != 0) begin
                recv_stall <= recv_stall - 1;
                out_ready  <= 1'b0;
            end else begin
                out_ready <= 1'b1;
                if (idling_allowed() && $urandom_range(0, 5) == 0)
                    recv_stall <= $urandom_range(1, 5);
            end
        end
    end

    // Wait for all requests and results, let the pipeline settle, then report
    initial begin
        @(posedge rst_n);
        while (request_q.size() != 0 || in_valid || expected_resp_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
        if (error_count == 0) begin
            $display("sorted_priority_queue_core verification clean");
        end else begin
            $display("sorted_priority_queue_core verification failed");
        end
        $finish;
    end

    // Watchdog far beyond the slowest legal run
    initial begin
        #2000000;
        $display("sorted_priority_queue_core verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/spq_pkg.sv
hdl/spq_cell.sv
hdl/sorted_priority_queue_core.sv
hdl/spq_checker.sv
tb/tb.sv
